// ===== rtl/bbsf_pkg.sv =====
// ----------------------------------------------------------------------------
// bbsf_pkg: shared types and constants for the balanced byte symbol framer
// Action and symbol kind codes, controller/datapath command and status
// structs, and the byte balancing function.
// ----------------------------------------------------------------------------
package bbsf_pkg;

   // field widths fixed by the interface
   localparam int TOTAL_LENGTH_W   = 64;
   localparam int LENGTH_BITS_DEF  = 64;
   localparam int GROUP_W          = 7;
   localparam int BALANCE_LIMIT    = 4;

   localparam logic [7:0] GROUP_MASK = 8'h7F;
   localparam logic [7:0] END_MARK   = 8'h80;

   // input item action codes
   typedef enum logic [1:0] {
      ACT_START  = 2'd0,
      ACT_DATA   = 2'd1,
      ACT_FINISH = 2'd2
   } action_type;

   // output symbol kinds
   typedef enum logic [1:0] {
      KIND_LENGTH = 2'd0,
      KIND_DATA   = 2'd1,
      KIND_CLOSE  = 2'd2
   } kind_type;

   // controller -> datapath
   typedef struct packed {
      logic load_len;    // capture length, force phase to one
      logic emit_group;  // emit next length group
      logic emit_data;   // emit data byte, lower the remaining count
      logic emit_close;  // emit closing sync symbol
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic slot_free;   // output register can take a symbol this cycle
      logic phase;       // current phase flag
      logic group_last;  // next length group is the final one
   } stat_type;

   // count of ones in a byte
   function automatic logic [3:0] ones_in_byte(input logic [7:0] b);
      logic [3:0] n;
      n = '0;
      for (int i = 0; i < 8; i++) begin
         n = n + {3'b000, b[i]};
      end
      return n;
   endfunction

   // balance a byte: bit 8 is the inverted flag, bits 7:0 the symbol bits
   function automatic logic [8:0] balance_byte(input logic [7:0] b);
      logic inv;
      inv = (ones_in_byte(b) > 4'(BALANCE_LIMIT));
      return {inv, inv ? ~b : b};
   endfunction

endpackage

// ===== rtl/bbsf_req_if.sv =====
// ----------------------------------------------------------------------------
// bbsf_req_if: input item channel
// Valid/ready channel carrying action, length and data byte.
// ----------------------------------------------------------------------------
interface bbsf_req_if import bbsf_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [1:0]                action;
   logic [TOTAL_LENGTH_W-1:0] total_length;
   logic [7:0]                data_byte;

   modport source (output valid, action, total_length, data_byte, input ready);
   modport sink   (input valid, action, total_length, data_byte, output ready);
endinterface

// ===== rtl/bbsf_rsp_if.sv =====
// ----------------------------------------------------------------------------
// bbsf_rsp_if: result symbol channel
// Valid/ready channel carrying one framed 10-bit symbol plus kind and last.
// ----------------------------------------------------------------------------
interface bbsf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] symbol_bits;
   logic       inverted;
   logic       sync_bit;
   logic [1:0] symbol_kind;
   logic       last;

   modport source (output valid, symbol_bits, inverted, sync_bit, symbol_kind, last,
                   input ready);
   modport sink   (input valid, symbol_bits, inverted, sync_bit, symbol_kind, last,
                   output ready);
endinterface

// ===== rtl/balanced_byte_symbol_framer_top.sv =====
// ----------------------------------------------------------------------------
// balanced_byte_symbol_framer_top: balanced byte symbol framer
// Frames a byte stream into 10-bit symbols (8 balanced bits, inverted
// flag, sync bit), with a 7-bit group length header and closing symbol.
//
//   channel   dir  handshake            payload
//   req_bus   in   valid/ready          action, total_length, data_byte
//   rsp_bus   out  valid/ready          symbol_bits, inverted, sync_bit,
//                                       symbol_kind, last
//
// Data and finish beats pass one per cycle while the output is not stalled.
// A start beat loads the group shifter, then emits the 7-bit length groups
// (up to ceil(LENGTH_BITS/7)) in turn while the input waits.
// The single output register accepts a new symbol in the cycle its
// previous one is taken; a stalled output stalls the input.
// Synchronous reset sets the phase flag to one and empties the output.
// ----------------------------------------------------------------------------
module balanced_byte_symbol_framer_top import bbsf_pkg::*; #(
   parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   bbsf_req_if.sink   req_bus,
   bbsf_rsp_if.source rsp_bus
);

   cmd_type  cmd;
   stat_type stat;

   // controller
   bbsf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_action (req_bus.action),
      .req_ready  (req_bus.ready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // datapath
   bbsf_datapath #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .total_length (req_bus.total_length),
      .data_byte    (req_bus.data_byte),
      .cmd          (cmd),
      .stat         (stat),
      .rsp          (rsp_bus)
   );

endmodule

// ===== rtl/bbsf_ctrl.sv =====
// ----------------------------------------------------------------------------
// bbsf_ctrl: framer controller
// Decodes accepted input beats and sequences the length group emission.
// ----------------------------------------------------------------------------
module bbsf_ctrl import bbsf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_action,
   output logic       req_ready,
   input  stat_type   stat,
   output cmd_type    cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_LEN
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   // input is taken only when idle and the output slot frees up
   assign req_ready = (state_ff == ST_IDLE) && stat.slot_free;
   assign accept    = req_valid && req_ready;

   // command decode
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_action)
                  ACT_START: begin
                     cmd.load_len = 1'b1;
                     state_in     = ST_LEN;
                  end
                  ACT_DATA:   cmd.emit_data  = 1'b1;
                  ACT_FINISH: cmd.emit_close = stat.phase;
                  default:    ;  // unused code: dropped
               endcase
            end
         end
         ST_LEN: begin
            if (stat.slot_free) begin
               cmd.emit_group = 1'b1;
               if (stat.group_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/bbsf_datapath.sv =====
// ----------------------------------------------------------------------------
// bbsf_datapath: framer datapath
// Length group shifter, phase flag, remaining count, balancing and the
// output symbol register.
// ----------------------------------------------------------------------------
module bbsf_datapath import bbsf_pkg::*; #(
   parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [TOTAL_LENGTH_W-1:0] total_length,
   input  logic [7:0]                data_byte,
   input  cmd_type                   cmd,
   output stat_type                  stat,
   bbsf_rsp_if.source                rsp
);

   logic [LENGTH_BITS-1:0] shift_ff, shift_in;
   logic [LENGTH_BITS-1:0] count_ff, count_in;
   logic                   phase_ff, phase_in;
   logic                   out_valid_ff, out_valid_in;
   logic [7:0]             out_bits_ff, out_bits_in;
   logic                   out_inv_ff, out_inv_in;
   logic                   out_sync_ff, out_sync_in;
   kind_type               out_kind_ff, out_kind_in;
   logic                   out_last_ff, out_last_in;

   logic                   rest_zero;
   logic                   emit_any;
   logic [7:0]             raw;
   logic [8:0]             balanced;

   assign rest_zero = ((shift_ff >> GROUP_W) == '0);
   assign emit_any  = cmd.emit_group || cmd.emit_data || cmd.emit_close;

   assign stat.slot_free  = !out_valid_ff || rsp.ready;
   assign stat.phase      = phase_ff;
   assign stat.group_last = rest_zero;

   // symbol selection and state update
   always_comb begin
      shift_in    = shift_ff;
      count_in    = count_ff;
      phase_in    = phase_ff;
      raw         = 8'h00;
      out_kind_in = out_kind_ff;
      out_last_in = out_last_ff;

      if (cmd.load_len) begin
         shift_in = total_length[LENGTH_BITS-1:0];
         count_in = total_length[LENGTH_BITS-1:0];
         phase_in = 1'b1;
      end

      if (cmd.emit_data) begin
         raw         = data_byte;
         out_kind_in = KIND_DATA;
         out_last_in = 1'b1;
         if (count_ff != '0) begin
            count_in = count_ff - 1'b1;
         end
      end else if (cmd.emit_close) begin
         out_kind_in = KIND_CLOSE;
         out_last_in = 1'b1;
      end else if (cmd.emit_group) begin
         out_kind_in = KIND_LENGTH;
         out_last_in = rest_zero;
         shift_in    = shift_ff >> GROUP_W;
         // zero length: plain 0x00 without end mark
         if (shift_ff != '0) begin
            raw = (8'(shift_ff[GROUP_W-1:0]) & GROUP_MASK) | (rest_zero ? END_MARK : 8'h00);
         end
      end

      if (emit_any) begin
         phase_in = !phase_ff;
      end
   end

   assign balanced    = balance_byte(raw);
   assign out_bits_in = emit_any ? balanced[7:0] : out_bits_ff;
   assign out_inv_in  = emit_any ? balanced[8]   : out_inv_ff;
   assign out_sync_in = emit_any ? phase_ff      : out_sync_ff;

   // output valid: set on emit, cleared when the beat is taken
   always_comb begin
      out_valid_in = out_valid_ff;
      if (emit_any) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= 1'b1;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      shift_ff    <= shift_in;
      out_bits_ff <= out_bits_in;
      out_inv_ff  <= out_inv_in;
      out_sync_ff <= out_sync_in;
      out_kind_ff <= out_kind_in;
      out_last_ff <= out_last_in;
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.symbol_bits = out_bits_ff;
   assign rsp.inverted    = out_inv_ff;
   assign rsp.sync_bit    = out_sync_ff;
   assign rsp.symbol_kind = out_kind_ff;
   assign rsp.last        = out_last_ff;

endmodule
